// ===== rtl/lbsm_pkg.sv =====
// lbsm_pkg: shared widths, constants, types and the band edge function
// for the log-band spectrum bar meter
// no dependencies

package lbsm_pkg;

   // default sizing of the block
   localparam int NUM_BINS_DEF = 256;
   localparam int BANDS_DEF    = 32;

   // field widths
   localparam int MAG_W      = 16;
   localparam int BAND_NUM_W = 6;
   localparam int TICK_W     = 10;
   localparam int HEIGHT_W   = 7;
   localparam int SMOOTH_W   = 8;

   // configuration register file
   localparam int                CSR_IDX_W      = 1;
   localparam int                CSR_DATA_W     = 8;
   localparam logic [CSR_IDX_W-1:0] REG_BAR_HEIGHT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_DECAY      = 1'b1;

   localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 7'd7;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 7'd64;
   localparam logic [SMOOTH_W-1:0] SMOOTH_RST = 8'd128;
   localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = 8'd253;

   // shared multiplier
   localparam int MUL_W  = 19;
   localparam int PROD_W = 2 * MUL_W;

   // floor(v / 5) = (v * RECIP5) >> RECIP5_SH for every v below 2^19
   localparam logic [MUL_W-1:0] RECIP5    = 19'd419431;
   localparam int               RECIP5_SH = 21;

   // band edges: floor(2^(EDGE_STEP * k / bands)), never above 128
   localparam int EDGE_W    = 9;
   localparam int EDGE_STEP = 7;
   localparam int EDGE_MAX  = 128;
   localparam int POW_W     = 512;

   // square root unit
   localparam int ROOT_W     = 10;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int ROOT_CNT_W = $clog2(ROOT_W);

   typedef struct packed {
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_op_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } root_stat_type;

   // largest n with n^bands <= 2^(EDGE_STEP*k), by binary search over n
   function automatic logic [EDGE_W-1:0] band_edge(input int k, input int bands);
      logic [POW_W-1:0] pw;
      logic [POW_W-1:0] lim;
      int               lo;
      int               hi;
      int               mid;
      lo  = 1;
      hi  = EDGE_MAX;
      lim = POW_W'(1) << (EDGE_STEP * k);
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         pw  = POW_W'(1);
         for (int i = 0; i < bands; i++) begin
            pw = pw * POW_W'(mid);
         end
         if (pw <= lim) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return EDGE_W'(lo);
   endfunction

endpackage

// ===== rtl/lbsm_bin_mem.sv =====
// lbsm_bin_mem: frame store of bin magnitudes, one write and one read port
// depends on lbsm_pkg

module lbsm_bin_mem #(
   parameter int  DEPTH  = lbsm_pkg::NUM_BINS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [lbsm_pkg::MAG_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [lbsm_pkg::MAG_W-1:0] rd_data
);

   logic [lbsm_pkg::MAG_W-1:0] store_ff [DEPTH];
   logic [lbsm_pkg::MAG_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lbsm_peak_mem.sv =====
// lbsm_peak_mem: held peak per band, with per-entry valid bits so that
// unwritten entries read as zero after reset; depends on lbsm_pkg

module lbsm_peak_mem #(
   parameter int  ADDR_W = 5,
   localparam int DEPTH  = 1 << ADDR_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [lbsm_pkg::MAG_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [lbsm_pkg::MAG_W-1:0] rd_data
);

   logic [lbsm_pkg::MAG_W-1:0] peak_ff [DEPTH];
   logic [DEPTH-1:0]           valid_ff;
   logic [DEPTH-1:0]           valid_in;
   logic [lbsm_pkg::MAG_W-1:0] rd_data_ff;
   logic                       rd_valid_ff;
   logic                       rd_valid_in;

   // valid bit set on first write of an entry
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // read valid follows the addressed entry on each read
   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (rd_en) begin
         rd_valid_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         peak_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= peak_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/lbsm_mul.sv =====
// lbsm_mul: shared registered multiplier used by every product of the band walk
// depends on lbsm_pkg

module lbsm_mul (
   input  logic                        clock,
   input  lbsm_pkg::mul_op_type        op,
   output logic [lbsm_pkg::PROD_W-1:0] product
);

   logic [lbsm_pkg::PROD_W-1:0] product_ff;
   logic [lbsm_pkg::PROD_W-1:0] product_in;

   // one multiply per cycle, result in the following cycle
   assign product_in = lbsm_pkg::PROD_W'(op.a) * lbsm_pkg::PROD_W'(op.b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== rtl/lbsm_isqrt.sv =====
// lbsm_isqrt: iterative integer square root, one result bit per cycle
// depends on lbsm_pkg

module lbsm_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lbsm_pkg::RAD_W-1:0]  radicand,
   output lbsm_pkg::root_stat_type     stat
);

   localparam int REM_W = lbsm_pkg::ROOT_W + 3;

   logic [lbsm_pkg::RAD_W-1:0]      rad_ff;
   logic [lbsm_pkg::RAD_W-1:0]      rad_in;
   logic [REM_W-1:0]                rem_ff;
   logic [REM_W-1:0]                rem_in;
   logic [lbsm_pkg::ROOT_W-1:0]     root_ff;
   logic [lbsm_pkg::ROOT_W-1:0]     root_in;
   logic [lbsm_pkg::ROOT_CNT_W-1:0] cnt_ff;
   logic [lbsm_pkg::ROOT_CNT_W-1:0] cnt_in;
   logic                            busy_ff;
   logic                            busy_in;
   logic                            done_ff;
   logic                            done_in;
   logic [REM_W-1:0]                rem_sh;
   logic [REM_W-1:0]                trial;

   // bring down the next two radicand bits and try the next root bit
   assign rem_sh = {rem_ff[lbsm_pkg::ROOT_W:0], rad_ff[lbsm_pkg::RAD_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = lbsm_pkg::ROOT_CNT_W'(lbsm_pkg::ROOT_W - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[lbsm_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[lbsm_pkg::ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign stat.done = done_ff;
   assign stat.root = root_ff;

endmodule

// ===== rtl/log_band_spectrum_bar_meter.sv =====
// Log-band spectrum bar meter. Bin requests are taken one per cycle and
// stored while the frame store has room; the request that carries frame_end
// starts the band walk, during which req_ready is low. The walk first squares
// the bar height, then for each band the sequencer sets up the span and reads
// the band's bins from the frame store one per cycle. It updates the held
// peak with the shared 19x19 multiplier (states UPD_A and UPD_B on attack,
// plus UPD_C on decay) and scales it by the height squared. It then takes a
// square root at one bit per cycle. With the default sizing the bands read
// 134 bins in all. Band results leave through an output register, so the walk
// runs on while one result waits. It holds at the end of the next band's
// square root until that result is taken.
// Registers: index 0 bar_height, index 1 decay_smoothing, written any time
// the block is idle; csr_ready is always high. Depends on lbsm_pkg.

module log_band_spectrum_bar_meter #(
   parameter int NUM_BINS = lbsm_pkg::NUM_BINS_DEF,
   parameter int BANDS    = lbsm_pkg::BANDS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lbsm_pkg::MAG_W-1:0]        req_bin_magnitude,
   input  logic                              req_frame_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lbsm_pkg::BAND_NUM_W-1:0]   rsp_band_number,
   output logic [lbsm_pkg::TICK_W-1:0]       rsp_bar_ticks,
   output logic                              rsp_last_band,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lbsm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lbsm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int ADDR_W = $clog2(NUM_BINS);
   localparam int CNT_W  = $clog2(NUM_BINS + 1);
   localparam int SPAN_W = (CNT_W > lbsm_pkg::EDGE_W) ? CNT_W : lbsm_pkg::EDGE_W;
   localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int EIDX_W = $clog2(BANDS + 1);
   localparam int MAG_W  = lbsm_pkg::MAG_W;
   localparam int MUL_W  = lbsm_pkg::MUL_W;
   localparam int HH_W   = 2 * lbsm_pkg::HEIGHT_W - 1;
   localparam int ACC_W  = 24;

   // sequencer states
   localparam logic [3:0] ST_COLLECT = 4'd0;
   localparam logic [3:0] ST_HSQ     = 4'd1;
   localparam logic [3:0] ST_BAND    = 4'd2;
   localparam logic [3:0] ST_SCAN    = 4'd3;
   localparam logic [3:0] ST_UPD_A   = 4'd4;
   localparam logic [3:0] ST_UPD_B   = 4'd5;
   localparam logic [3:0] ST_UPD_C   = 4'd6;
   localparam logic [3:0] ST_SCALE   = 4'd7;
   localparam logic [3:0] ST_ROOT_GO = 4'd8;
   localparam logic [3:0] ST_ROOT    = 4'd9;

   logic [3:0]                        state_ff;
   logic [3:0]                        state_in;
   logic [CNT_W-1:0]                  count_ff;
   logic [CNT_W-1:0]                  count_in;
   logic [CNT_W-1:0]                  frame_len_ff;
   logic [CNT_W-1:0]                  frame_len_in;
   logic [BAND_W-1:0]                 band_ff;
   logic [BAND_W-1:0]                 band_in;
   logic [SPAN_W-1:0]                 addr_ff;
   logic [SPAN_W-1:0]                 addr_in;
   logic [SPAN_W-1:0]                 end_ff;
   logic [SPAN_W-1:0]                 end_in;
   logic                              pend_ff;
   logic                              pend_in;
   logic [MAG_W-1:0]                  peak_ff;
   logic [MAG_W-1:0]                  peak_in;
   logic                              attack_ff;
   logic                              attack_in;
   logic [ACC_W-1:0]                  acc_ff;
   logic [ACC_W-1:0]                  acc_in;
   logic [MAG_W-1:0]                  held_new_ff;
   logic [MAG_W-1:0]                  held_new_in;
   logic [HH_W-1:0]                   hh_ff;
   logic [HH_W-1:0]                   hh_in;
   logic [lbsm_pkg::HEIGHT_W-1:0]     bar_height_ff;
   logic [lbsm_pkg::HEIGHT_W-1:0]     bar_height_in;
   logic [lbsm_pkg::SMOOTH_W-1:0]     decay_ff;
   logic [lbsm_pkg::SMOOTH_W-1:0]     decay_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [lbsm_pkg::BAND_NUM_W-1:0]   rsp_band_ff;
   logic [lbsm_pkg::BAND_NUM_W-1:0]   rsp_band_in;
   logic [lbsm_pkg::TICK_W-1:0]       rsp_ticks_ff;
   logic [lbsm_pkg::TICK_W-1:0]       rsp_ticks_in;
   logic                              rsp_last_ff;
   logic                              rsp_last_in;

   logic [lbsm_pkg::EDGE_W-1:0]       edge_tab [BANDS + 1];
   logic [EIDX_W-1:0]                 eidx_lo;
   logic [EIDX_W-1:0]                 eidx_hi;
   logic [SPAN_W-1:0]                 span_st;
   logic [SPAN_W-1:0]                 span_en_raw;
   logic [SPAN_W-1:0]                 span_en_min;
   logic [SPAN_W-1:0]                 span_en;
   logic [SPAN_W-1:0]                 frame_len_ext;
   logic [lbsm_pkg::HEIGHT_W-1:0]     h_cl;
   logic [lbsm_pkg::SMOOTH_W-1:0]     s_cl;
   logic [lbsm_pkg::TICK_W-1:0]       tick_lim;
   logic [lbsm_pkg::TICK_W-1:0]       ticks_sat;
   logic                              bin_wr;
   logic                              scan_rd;
   logic [MAG_W-1:0]                  bin_rd_data;
   logic                              peak_rd;
   logic                              peak_wr;
   logic [MAG_W-1:0]                  held_rd;
   logic                              attack;
   logic                              band_last;
   logic                              rsp_free;
   logic                              root_start;
   logic [lbsm_pkg::RAD_W-1:0]        radicand;
   logic [ACC_W:0]                    decay_sum;
   lbsm_pkg::mul_op_type              mul_op;
   logic [lbsm_pkg::PROD_W-1:0]       product;
   lbsm_pkg::root_stat_type           root_stat;

   // band edge table, worked out at elaboration
   for (genvar k = 0; k <= BANDS; k++) begin : g_edge
      assign edge_tab[k] = lbsm_pkg::band_edge(k, BANDS);
   end

   // band span: at least one bin, capped at the bins stored
   assign eidx_lo       = EIDX_W'(band_ff);
   assign eidx_hi       = eidx_lo + EIDX_W'(1);
   assign span_st       = SPAN_W'(edge_tab[eidx_lo]);
   assign span_en_raw   = SPAN_W'(edge_tab[eidx_hi]);
   assign frame_len_ext = SPAN_W'(frame_len_ff);
   assign span_en_min   = (span_en_raw <= span_st) ? span_st + SPAN_W'(1) : span_en_raw;
   assign span_en       = (span_en_min > frame_len_ext) ? frame_len_ext : span_en_min;

   // clamped configuration
   assign h_cl     = (bar_height_ff > lbsm_pkg::HEIGHT_MAX) ? lbsm_pkg::HEIGHT_MAX
                                                           : bar_height_ff;
   assign s_cl     = (decay_ff > lbsm_pkg::SMOOTH_MAX) ? lbsm_pkg::SMOOTH_MAX : decay_ff;
   assign tick_lim = lbsm_pkg::TICK_W'({h_cl, 3'b000});

   // band walk helpers
   assign scan_rd   = (state_ff == ST_SCAN) && (addr_ff < end_ff);
   assign attack    = peak_ff >= held_rd;
   assign band_last = band_ff == BAND_W'(BANDS - 1);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign decay_sum = (ACC_W + 1)'(acc_ff) + (ACC_W + 1)'(product[ACC_W-1:0]);
   assign radicand  = lbsm_pkg::RAD_W'(product[27:9]);
   assign ticks_sat = (root_stat.root > tick_lim) ? tick_lim : root_stat.root;

   assign req_ready  = state_ff == ST_COLLECT;
   assign bin_wr     = req_ready && req_valid && (count_ff < CNT_W'(NUM_BINS));
   assign peak_rd    = state_ff == ST_BAND;
   assign peak_wr    = state_ff == ST_SCALE;
   assign root_start = state_ff == ST_ROOT_GO;

   // operand selection for the shared multiplier
   always_comb begin
      mul_op = '0;
      unique case (state_ff)
         ST_HSQ: begin
            mul_op.a = MUL_W'(h_cl);
            mul_op.b = MUL_W'(h_cl);
         end
         ST_UPD_A: begin
            if (attack) begin
               mul_op.a = MUL_W'({peak_ff, 2'b00}) + MUL_W'(held_rd);
               mul_op.b = lbsm_pkg::RECIP5;
            end else begin
               mul_op.a = MUL_W'(held_rd);
               mul_op.b = MUL_W'(s_cl);
            end
         end
         ST_UPD_B: begin
            mul_op.a = MUL_W'(peak_ff);
            mul_op.b = MUL_W'(9'd256 - 9'(s_cl));
         end
         ST_SCALE: begin
            mul_op.a = MUL_W'(held_new_ff);
            mul_op.b = MUL_W'(hh_ff);
         end
         default: begin
            mul_op = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      frame_len_in = frame_len_ff;
      band_in      = band_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      pend_in      = pend_ff;
      peak_in      = peak_ff;
      attack_in    = attack_ff;
      acc_in       = acc_ff;
      held_new_in  = held_new_ff;
      hh_in        = hh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_band_in  = rsp_band_ff;
      rsp_ticks_in = rsp_ticks_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_valid) begin
               if (bin_wr) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_frame_end) begin
                  frame_len_in = bin_wr ? count_ff + CNT_W'(1) : count_ff;
                  count_in     = '0;
                  state_in     = ST_HSQ;
               end
            end
         end
         ST_HSQ: begin
            band_in  = '0;
            state_in = ST_BAND;
         end
         ST_BAND: begin
            // height square arrives here for the first band
            if (band_ff == '0) begin
               hh_in = product[HH_W-1:0];
            end
            addr_in  = span_st;
            end_in   = span_en;
            peak_in  = '0;
            pend_in  = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            pend_in = scan_rd;
            if (scan_rd) begin
               addr_in = addr_ff + SPAN_W'(1);
            end
            if (pend_ff && (bin_rd_data > peak_ff)) begin
               peak_in = bin_rd_data;
            end
            if (!scan_rd && !pend_ff) begin
               state_in = ST_UPD_A;
            end
         end
         ST_UPD_A: begin
            attack_in = attack;
            state_in  = ST_UPD_B;
         end
         ST_UPD_B: begin
            if (attack_ff) begin
               held_new_in = product[lbsm_pkg::RECIP5_SH + MAG_W - 1 : lbsm_pkg::RECIP5_SH];
               state_in    = ST_SCALE;
            end else begin
               acc_in   = product[ACC_W-1:0];
               state_in = ST_UPD_C;
            end
         end
         ST_UPD_C: begin
            held_new_in = decay_sum[ACC_W-1:8];
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_stat.done && rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_band_in  = lbsm_pkg::BAND_NUM_W'(band_ff);
               rsp_ticks_in = ticks_sat;
               rsp_last_in  = band_last;
               if (band_last) begin
                  state_in = ST_COLLECT;
               end else begin
                  band_in  = band_ff + BAND_W'(1);
                  state_in = ST_BAND;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      bar_height_in = bar_height_ff;
      decay_in      = decay_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lbsm_pkg::REG_BAR_HEIGHT: bar_height_in = csr_data[lbsm_pkg::HEIGHT_W-1:0];
            lbsm_pkg::REG_DECAY:      decay_in      = csr_data[lbsm_pkg::SMOOTH_W-1:0];
            default: begin
               bar_height_in = bar_height_ff;
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_COLLECT;
         count_ff      <= '0;
         band_ff       <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bar_height_ff <= lbsm_pkg::HEIGHT_RST;
         decay_ff      <= lbsm_pkg::SMOOTH_RST;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         band_ff       <= band_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         bar_height_ff <= bar_height_in;
         decay_ff      <= decay_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      frame_len_ff <= frame_len_in;
      addr_ff      <= addr_in;
      end_ff       <= end_in;
      peak_ff      <= peak_in;
      attack_ff    <= attack_in;
      acc_ff       <= acc_in;
      held_new_ff  <= held_new_in;
      hh_ff        <= hh_in;
      rsp_band_ff  <= rsp_band_in;
      rsp_ticks_ff <= rsp_ticks_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_band_number = rsp_band_ff;
   assign rsp_bar_ticks   = rsp_ticks_ff;
   assign rsp_last_band   = rsp_last_ff;

   // frame store
   lbsm_bin_mem #(
      .DEPTH (NUM_BINS)
   ) u_bin_mem (
      .clock   (clock),
      .wr_en   (bin_wr),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_bin_magnitude),
      .rd_en   (scan_rd),
      .rd_addr (addr_ff[ADDR_W-1:0]),
      .rd_data (bin_rd_data)
   );

   // held peaks
   lbsm_peak_mem #(
      .ADDR_W (BAND_W)
   ) u_peak_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (peak_wr),
      .wr_addr (band_ff),
      .wr_data (held_new_ff),
      .rd_en   (peak_rd),
      .rd_addr (band_ff),
      .rd_data (held_rd)
   );

   // shared multiplier
   lbsm_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .product (product)
   );

   // square root unit
   lbsm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .stat     (root_stat)
   );

endmodule

// ===== dv/lbsm_meter_tb_pkg.sv =====
// lbsm_meter_tb_pkg: scoreboard for the log-band spectrum bar meter bench,
// holding its own band walk, held peaks and register copies
// depends on lbsm_pkg for widths, sizing and register indexes

package lbsm_meter_tb_pkg;

   import lbsm_pkg::*;

   typedef struct packed {
      logic [BAND_NUM_W-1:0] band;
      logic [TICK_W-1:0]     ticks;
      logic                  last;
   } bar_level_type;

   class bar_scoreboard;
      int unsigned         errors;
      logic [MAG_W-1:0]    frame_bins [NUM_BINS_DEF];
      int unsigned         bins_seen;
      logic [MAG_W-1:0]    held_peak [BANDS_DEF];
      logic [HEIGHT_W-1:0] height;
      logic [SMOOTH_W-1:0] smoothing;
      int unsigned         band_start [BANDS_DEF + 1];
      bar_level_type       expected_bars [$];

      // largest n whose BANDS-th power stays within 2^(7k), searched from the top
      function int unsigned log_edge(int k);
         logic [511:0] pw;
         for (int n = EDGE_MAX; n > 1; n--) begin
            pw = 512'd1;
            repeat (BANDS_DEF) pw = pw * 512'(n);
            if (pw <= (512'd1 << (EDGE_STEP * k))) return n;
         end
         return 1;
      endfunction

      function new();
         errors    = 0;
         bins_seen = 0;
         height    = HEIGHT_RST;
         smoothing = SMOOTH_RST;
         foreach (held_peak[i]) held_peak[i] = '0;
         for (int k = 0; k <= BANDS_DEF; k++) band_start[k] = log_edge(k);
      endfunction

      // integer square root, one result bit at a time
      function int unsigned root_floor(int unsigned v);
         int unsigned r;
         int unsigned t;
         r = 0;
         for (int b = 15; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (t * t <= v) r = t;
         end
         return r;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_BAR_HEIGHT: height = data[HEIGHT_W-1:0];
            REG_DECAY:      smoothing = data[SMOOTH_W-1:0];
            default: ;
         endcase
      endfunction

      // band maxima, held peak update and bar levels for the finished frame
      function void walk_bands();
         int unsigned   h;
         int unsigned   s;
         int unsigned   lim;
         int unsigned   st;
         int unsigned   en;
         int unsigned   peak;
         int unsigned   held;
         int unsigned   ticks;
         bar_level_type lvl;
         h   = (height > HEIGHT_MAX) ? HEIGHT_MAX : height;
         s   = (smoothing > SMOOTH_MAX) ? SMOOTH_MAX : smoothing;
         lim = 8 * h;
         for (int x = 0; x < BANDS_DEF; x++) begin
            st = band_start[x];
            en = band_start[x + 1];
            if (en <= st) en = st + 1;
            if (en > bins_seen) en = bins_seen;
            peak = 0;
            for (int unsigned b = st; b < en; b++)
               if (frame_bins[b] > peak) peak = frame_bins[b];
            held = held_peak[x];
            // slow decay below the held peak, fast attack otherwise
            if (peak < held) held = (held * s + peak * (256 - s)) >> 8;
            else held = (4 * peak + held) / 5;
            held_peak[x] = held[MAG_W-1:0];
            ticks = root_floor((held_peak[x] * h * h) >> 9);
            if (ticks > lim) ticks = lim;
            lvl.band  = x[BAND_NUM_W-1:0];
            lvl.ticks = ticks[TICK_W-1:0];
            lvl.last  = (x == BANDS_DEF - 1);
            expected_bars = {expected_bars, lvl};
         end
         bins_seen = 0;
      endfunction

      // accepted bin request; a full store drops the bin but frame end still counts
      function void note_bin(logic [MAG_W-1:0] mag, logic fend);
         if (bins_seen < NUM_BINS_DEF) begin
            frame_bins[bins_seen] = mag;
            bins_seen++;
         end
         if (fend) walk_bands();
      endfunction

      function void check_bar(logic [BAND_NUM_W-1:0] band, logic [TICK_W-1:0] ticks,
                              logic last);
         bar_level_type want;
         if (expected_bars.size() == 0) begin
            $error("unexpected bar result for band %0d", band);
            errors++;
            return;
         end
         want = expected_bars.pop_front();
         if (band !== want.band) begin
            $error("band_number: expected %0d, got %0d", want.band, band);
            errors++;
         end
         if (ticks !== want.ticks) begin
            $error("bar_ticks: expected %0d, got %0d", want.ticks, ticks);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_band: expected %0d, got %0d", want.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_bars.size();
      endfunction
   endclass

endpackage

// ===== dv/log_band_spectrum_bar_meter_tb.sv =====
// log_band_spectrum_bar_meter_tb: drives bin frames and register writes into the
// bar meter and checks every band result against the scoreboard's prediction
// depends on lbsm_pkg, lbsm_meter_tb_pkg and the bar meter rtl

module log_band_spectrum_bar_meter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lbsm_pkg::*;
   import lbsm_meter_tb_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_BINS    = 25;

   typedef enum int {MAG_ZERO, MAG_MAX, MAG_FULL, MAG_LOW, MAG_SPARSE, MAG_TOP} mag_style_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [MAG_W-1:0]      req_bin_magnitude;
   logic                  req_frame_end;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [BAND_NUM_W-1:0] rsp_band_number;
   logic [TICK_W-1:0]     rsp_bar_ticks;
   logic                  rsp_last_band;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   bar_scoreboard sb = new();
   int            req_gap_pct;
   int            rsp_stall_pct;
   int            bins_sent;

   log_band_spectrum_bar_meter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_bin_magnitude (req_bin_magnitude),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_band_number   (rsp_band_number),
      .rsp_bar_ticks     (rsp_bar_ticks),
      .rsp_last_band     (rsp_last_band),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #30ms;
      $display("FAILED: results differ");
      $finish;
   end

   // result side: check each accepted bar, idle on a random share of cycles
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_bar(rsp_band_number, rsp_bar_ticks, rsp_last_band);
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic logic [MAG_W-1:0] pick_mag(mag_style_type style);
      case (style)
         MAG_ZERO:   return '0;
         MAG_MAX:    return '1;
         MAG_LOW:    return MAG_W'($urandom_range(0, 2047));
         MAG_SPARSE: return ($urandom_range(3) == 0) ? MAG_W'($urandom) : '0;
         MAG_TOP:    return ($urandom_range(3) == 0) ? MAG_W'($urandom) : '1;
         default:    return MAG_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_height();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'd64;
         3:       return 8'd127;
         4:       return 8'($urandom_range(65, 127));
         default: return 8'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_decay();
      case ($urandom_range(6))
         0:       return 8'd0;
         1:       return 8'd253;
         2:       return 8'($urandom_range(254, 255));
         default: return 8'($urandom);
      endcase
   endfunction

   // one bin request, with idle cycles ahead of it on a random share of cycles
   task automatic send_bin(input logic [MAG_W-1:0] mag, input logic fend);
      while (req_gap_pct > 0 && $urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_bin_magnitude <= mag;
      req_frame_end     <= fend;
      do @(posedge clock); while (!req_ready);
      sb.note_bin(mag, fend);
      bins_sent++;
   endtask

   task automatic send_frame(input int len, input mag_style_type style);
      for (int i = 0; i < len; i++) send_bin(pick_mag(style), i == len - 1);
   endtask

   // random frame of at most room bins
   task automatic random_frame(input int room);
      int            pick;
      int            len;
      mag_style_type style;
      pick = $urandom_range(99);
      if (pick < 60) len = $urandom_range(1, 16);
      else if (pick < 88) len = $urandom_range(17, 127);
      else len = $urandom_range(128, 140);
      if (len > room) len = room;
      if ($urandom_range(99) < 40) style = MAG_FULL;
      else style = mag_style_type'($urandom_range(MAG_ZERO, MAG_TOP));
      send_frame(len, style);
   endtask

   // let every band result come out and the walk settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register writes, only with the block idle
   task automatic configure(input bit set_height, input logic [CSR_DATA_W-1:0] height,
                            input bit set_decay, input logic [CSR_DATA_W-1:0] decay);
      wait_idle();
      if (set_height) begin
         csr_valid <= 1'b1;
         csr_index <= REG_BAR_HEIGHT;
         csr_data  <= height;
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(REG_BAR_HEIGHT, height);
      end
      if (set_decay) begin
         csr_valid <= 1'b1;
         csr_index <= REG_DECAY;
         csr_data  <= decay;
         do @(posedge clock); while (!csr_ready);
         sb.write_reg(REG_DECAY, decay);
      end
      csr_valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      int target;
      int mask;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_bin_magnitude <= '0;
      req_frame_end     <= 1'b0;
      csr_valid         <= 1'b0;
      csr_index         <= REG_BAR_HEIGHT;
      csr_data          <= '0;
      bins_sent     = 0;
      req_gap_pct   = 34;
      rsp_stall_pct = 45;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single bin frame under reset settings: every band is empty
      send_frame(1, MAG_MAX);
      // full-scale bins, attack towards saturation
      send_frame(3, MAG_MAX);
      // tallest bars, no smoothing: held peak drops straight to the band maximum
      configure(1'b1, 8'd64, 1'b1, 8'd0);
      send_frame(4, MAG_ZERO);
      send_frame(6, MAG_MAX);
      // zero height gives zero ticks
      configure(1'b1, 8'd0, 1'b0, 8'd0);
      send_frame(2, MAG_FULL);
      // height and smoothing above their ranges
      configure(1'b1, 8'd127, 1'b1, 8'd255);
      send_frame(5, MAG_ZERO);
      // smallest bar, slowest decay
      configure(1'b1, 8'd1, 1'b1, 8'd253);
      send_frame(3, MAG_MAX);

      // random frames over three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         req_gap_pct   = (phase == 0) ? 34 : (phase == 1) ? 45 : 0;
         rsp_stall_pct = (phase == 0) ? 45 : (phase == 1) ? 34 : 0;
         configure(1'b1, pick_height(), 1'b1, pick_decay());
         // overfilled store, frame end lands on a dropped bin
         if (phase == 1) send_frame(NUM_BINS_DEF + 3, MAG_FULL);
         target = bins_sent + PHASE_BINS;
         while (bins_sent < target) begin
            if ($urandom_range(4) == 0) begin
               mask = $urandom_range(1, 3);
               configure(mask[0], pick_height(), mask[1], pick_decay());
            end
            random_frame(target - bins_sent);
         end
      end

      wait_idle();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
